@@ src/image_mse_accumulator_core_defines.svh @@
// ----------------------------------------------------------------------------
// image mse accumulator assertion macros
// Concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef IMAGE_MSE_ACCUMULATOR_CORE_DEFINES_SVH
`define IMAGE_MSE_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// plain property, reset disables
`define MSE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// overlapping implication, reset disables
`define MSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define MSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define MSE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/mse_acc_pkg.sv @@
// ----------------------------------------------------------------------------
// mse_acc_pkg
// Shared widths, limits and payload types of the image mse accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package mse_acc_pkg;

	localparam int unsigned PIX_W      = 8;
	localparam int unsigned PAIR_W     = 21;
	localparam int unsigned SUM_W      = 36;
	localparam int unsigned MSE_W      = 24;
	localparam int unsigned FRAC_W     = 8;
	localparam int unsigned SQ_W       = 2 * PIX_W;
	localparam int unsigned MAX_PIXELS = 1048576;

	localparam logic [PAIR_W-1:0] MAX_PAIRS = PAIR_W'(MAX_PIXELS);

	// one quotient bit per divider step
	localparam int unsigned DIV_STEPS = MSE_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [PIX_W-1:0] pixel_a;
		logic [PIX_W-1:0] pixel_b;
		logic             last_pair;
	} in_item_t;

	typedef struct packed {
		logic [PAIR_W-1:0] pair_count;
		logic [PAIR_W-1:0] differing_count;
		logic [SUM_W-1:0]  square_sum;
		logic [MSE_W-1:0]  mse_q8;
		logic              overflow;
	} out_item_t;

	// accumulator contents
	typedef struct packed {
		logic [PAIR_W-1:0] pairs;
		logic [PAIR_W-1:0] diffs;
		logic [SUM_W-1:0]  sum;
		logic              ovf;
	} acc_t;

endpackage

`default_nettype wire

@@ src/mse_acc_accum.sv @@
// ----------------------------------------------------------------------------
// mse_acc_accum
// Squared difference and running accumulators, one pixel pair per cycle while take is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mse_acc_accum (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   take,
	input  mse_acc_pkg::in_item_t item,
	output mse_acc_pkg::acc_t     acc_next
);
	import mse_acc_pkg::*;

	acc_t              acc_q;
	logic [PIX_W-1:0]  diff;
	logic [SQ_W-1:0]   square;
	logic              full;

	assign diff   = (item.pixel_a >= item.pixel_b) ? (item.pixel_a - item.pixel_b)
	                                               : (item.pixel_b - item.pixel_a);
	assign square = SQ_W'(diff) * SQ_W'(diff);
	assign full   = (acc_q.pairs == MAX_PAIRS);

	always_comb begin
		acc_next = acc_q;
		if (full) begin
			acc_next.ovf = 1'b1;
		end else begin
			acc_next.sum   = acc_q.sum + SUM_W'(square);
			acc_next.pairs = acc_q.pairs + PAIR_W'(1);
			if (diff != '0) begin
				acc_next.diffs = acc_q.diffs + PAIR_W'(1);
			end
		end
	end

	// cleared after the last pair of an image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (take) begin
			if (item.last_pair) begin
				acc_q <= '0;
			end else begin
				acc_q <= acc_next;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/mse_acc_div.sv @@
// ----------------------------------------------------------------------------
// mse_acc_div
// Restoring divider, one quotient bit per cycle: floor(sum * 256 / count).
// ----------------------------------------------------------------------------
`default_nettype none

module mse_acc_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire [mse_acc_pkg::SUM_W-1:0]      start_sum,
	input  wire [mse_acc_pkg::PAIR_W-1:0]     start_count,
	output logic                              done,
	output logic [mse_acc_pkg::MSE_W-1:0]     quotient
);
	import mse_acc_pkg::*;

	logic [PAIR_W-1:0] divisor_q;
	logic [PAIR_W-1:0] rem_q;
	logic [MSE_W-1:0]  work_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [PAIR_W:0]   trial;
	logic [PAIR_W:0]   trial_sub;
	logic              fits;

	assign trial     = {rem_q, work_q[MSE_W-1]};
	assign fits      = (trial >= {1'b0, divisor_q});
	assign trial_sub = trial - {1'b0, divisor_q};

	// sum is at most 255^2 per pair, so the quotient fits MSE_W bits and the
	// dividend bits above it start out below the divisor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend bits shift out of work_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= start_count;
			rem_q     <= PAIR_W'(start_sum >> (MSE_W - FRAC_W));
			work_q    <= {start_sum[MSE_W-FRAC_W-1:0], FRAC_W'(0)};
		end else if (busy_q) begin
			rem_q  <= fits ? trial_sub[PAIR_W-1:0] : trial[PAIR_W-1:0];
			work_q <= {work_q[MSE_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = work_q;

endmodule

`default_nettype wire

@@ src/image_mse_accumulator_core.sv @@
// An ordinary pixel pair is taken when in_valid meets in_ready, one pair per
// cycle while in_ready is high. A last pair starts 24 divider steps, one
// quotient bit per cycle, then the done pulse and the output register load,
// which waits on an unread result. Input is not ready until that load.
// Reset (arst_n, asynchronous, active low) clears accumulators and control.
// ----------------------------------------------------------------------------
// image_mse_accumulator_core
// Mean squared error of two 8-bit images, streamed one pixel pair at a time.
// ----------------------------------------------------------------------------
`default_nettype none
`include "image_mse_accumulator_core_defines.svh"

module image_mse_accumulator_core (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  mse_acc_pkg::in_item_t  in_data,
	output logic                   out_valid,
	input  wire                    out_ready,
	output mse_acc_pkg::out_item_t out_data
);
	import mse_acc_pkg::*;

	localparam logic [1:0] ST_ACCUM = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_DONE  = 2'd2;

	logic [1:0]       state_q;
	acc_t             acc_next;
	acc_t             snap_q;
	logic             take;
	logic             last_take;
	logic             div_done;
	logic [MSE_W-1:0] quotient;
	logic             load_out;
	logic             out_valid_q;
	out_item_t        out_data_q;

	assign in_ready  = (state_q == ST_ACCUM);
	assign take      = in_valid && in_ready;
	assign last_take = take && in_data.last_pair;
	assign load_out  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	mse_acc_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.item     (in_data),
		.acc_next (acc_next)
	);

	mse_acc_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (last_take),
		.start_sum   (acc_next.sum),
		.start_count (acc_next.pairs),
		.done        (div_done),
		.quotient    (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
		end else begin
			case (state_q)
				ST_ACCUM: begin
					if (last_take) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_ACCUM;
					end
				end
				default: begin
					state_q <= ST_ACCUM;
				end
			endcase
		end
	end

	// totals of the image, including its last pair
	always_ff @(posedge clk) begin
		if (last_take) begin
			snap_q <= acc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.pair_count      <= snap_q.pairs;
			out_data_q.differing_count <= snap_q.diffs;
			out_data_q.square_sum      <= snap_q.sum;
			out_data_q.mse_q8          <= quotient;
			out_data_q.overflow        <= snap_q.ovf;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	`MSE_ASSERT_IMPL(a_done_in_div, clk, arst_n, div_done, state_q == ST_DIV,
		"divider finished outside divide state")
	`MSE_ASSERT(a_done_pulse, clk, arst_n, div_done |=> !div_done,
		"divider done held longer than one cycle")
	`MSE_ASSERT_IMPL(a_count_nonzero, clk, arst_n, out_valid_q,
		out_data_q.pair_count != '0, "result transaction with zero pair count")
	`MSE_ASSERT_IMPL(a_ovf_saturated, clk, arst_n, out_valid_q && out_data_q.overflow,
		out_data_q.pair_count == MAX_PAIRS, "overflow without saturated pair count")

endmodule

`default_nettype wire

@@ test/tb_image_mse_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// tb_image_mse_accumulator_core
// Streams pixel pairs into the mse accumulator with bursty input and a stalling
// output, predicts each image's counts, sum and mse, and checks every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_image_mse_accumulator_core;

	import mse_acc_pkg::*;

	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned LONG_HOLD  = 500;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	image_mse_accumulator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// stimulus and expectations
	in_item_t  pending_pairs[$];
	out_item_t image_results[$];

	// predicted accumulator state
	logic [SUM_W-1:0]  acc_sum   = '0;
	logic [PAIR_W-1:0] acc_pairs = '0;
	logic [PAIR_W-1:0] acc_diffs = '0;
	logic              acc_ovf   = 1'b0;

	int   err_count     = 0;
	int   images_done   = 0;
	int   pairs_taken   = 0;
	int   ovf_images    = 0;
	logic in_taken      = 1'b0;
	bit   sender_gaps   = 1'b1;
	int   long_holds    = 0;

	function automatic void push_pair(input int a, input int b, input bit last);
		in_item_t p;
		p.pixel_a   = PIX_W'(a);
		p.pixel_b   = PIX_W'(b);
		p.last_pair = last;
		pending_pairs.push_back(p);
	endfunction

	// fold one pair into the running image, close the image on its last pair
	function automatic void absorb_pair(input in_item_t p);
		logic [PIX_W-1:0] d;
		logic [43:0]      num;
		logic [43:0]      quo;
		out_item_t        r;
		d = (p.pixel_a >= p.pixel_b) ? p.pixel_a - p.pixel_b : p.pixel_b - p.pixel_a;
		if (acc_pairs < MAX_PAIRS) begin
			acc_sum   = acc_sum + SUM_W'(d) * SUM_W'(d);
			acc_pairs = acc_pairs + 1'b1;
			if (d != 0)
				acc_diffs = acc_diffs + 1'b1;
		end else begin
			acc_ovf = 1'b1;
		end
		if (p.last_pair) begin
			num = {acc_sum, 8'h00};
			quo = (acc_pairs != 0) ? num / 44'(acc_pairs) : '0;
			r.pair_count      = acc_pairs;
			r.differing_count = acc_diffs;
			r.square_sum      = acc_sum;
			r.mse_q8          = quo[MSE_W-1:0];
			r.overflow        = acc_ovf;
			image_results.push_back(r);
			acc_sum   = '0;
			acc_pairs = '0;
			acc_diffs = '0;
			acc_ovf   = 1'b0;
		end
	endfunction

	// one image of n pairs; style shapes the pixel content
	function automatic void queue_image(input int n, input int style);
		int a;
		int b;
		for (int i = 0; i < n; i++) begin
			a = $urandom_range(255);
			case (style)
				1: begin
					b = a;
				end
				2: begin
					a = $urandom_range(1) ? 255 : 0;
					b = $urandom_range(1) ? 255 : 0;
				end
				3: begin
					b = a + $urandom_range(4) - 2;
					if (b < 0) b = 0;
					if (b > 255) b = 255;
				end
				default: begin
					b = $urandom_range(255);
				end
			endcase
			push_pair(a, b, i == n - 1);
		end
	endfunction

	// driver: bursts of transactions separated by random gaps
	int burst_left = 1;
	int gap_left   = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (sender_gaps && gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_pairs.size() != 0) begin
				in_data  <= pending_pairs.pop_front();
				in_valid <= 1'b1;
				burst_left = burst_left - 1;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 48);
					gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stall rate redrawn each time stall_tick wraps, plus requested long holds
	int stall_pct  = 0;
	int stall_tick = 0;
	int hold_left  = 0;
	int holds_done = 0;

	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_ready <= 1'b0;
		end else if (holds_done != long_holds) begin
			holds_done = holds_done + 1;
			hold_left  = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			stall_tick = stall_tick + 1;
			if (stall_tick == 64) begin
				stall_tick = 0;
				case ($urandom_range(3))
					0:       stall_pct = 0;
					1:       stall_pct = 30;
					2:       stall_pct = 60;
					default: stall_pct = 90;
				endcase
			end
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// monitor: predict on input transactions, check on output transactions
	always @(posedge clk) begin
		out_item_t want;
		in_taken <= in_valid && in_ready;
		if (arst_n && in_valid && in_ready) begin
			absorb_pair(in_data);
			pairs_taken = pairs_taken + 1;
		end
		if (arst_n && out_valid && out_ready) begin
			if (image_results.size() == 0) begin
				$display("%0t: unexpected result, got %p", $time, out_data);
				err_count = err_count + 1;
			end else begin
				want = image_results.pop_front();
				if (out_data.pair_count !== want.pair_count) begin
					$display("%0t: pair_count expected %0d got %0d", $time,
						want.pair_count, out_data.pair_count);
					err_count = err_count + 1;
				end
				if (out_data.differing_count !== want.differing_count) begin
					$display("%0t: differing_count expected %0d got %0d", $time,
						want.differing_count, out_data.differing_count);
					err_count = err_count + 1;
				end
				if (out_data.square_sum !== want.square_sum) begin
					$display("%0t: square_sum expected %0d got %0d", $time,
						want.square_sum, out_data.square_sum);
					err_count = err_count + 1;
				end
				if (out_data.mse_q8 !== want.mse_q8) begin
					$display("%0t: mse_q8 expected %0d got %0d", $time,
						want.mse_q8, out_data.mse_q8);
					err_count = err_count + 1;
				end
				if (out_data.overflow !== want.overflow) begin
					$display("%0t: overflow expected %0b got %0b", $time,
						want.overflow, out_data.overflow);
					err_count = err_count + 1;
				end
				if (want.overflow)
					ovf_images = ovf_images + 1;
				images_done = images_done + 1;
			end
		end
	end

	// watchdog on cycles with no transaction on either side
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_pairs.size() != 0 || in_valid)
			@(posedge clk);
		while (image_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		int queued;
		int n;
		int pick;
		int i;

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// directed: single-pair images at the extremes, bit patterns, max mse
		push_pair(0, 0, 1);
		push_pair(255, 0, 1);
		push_pair(0, 255, 1);
		push_pair(255, 255, 1);
		push_pair(128, 128, 0);
		push_pair(1, 0, 0);
		push_pair(0, 1, 0);
		push_pair(170, 85, 0);
		push_pair(85, 170, 1);
		push_pair(255, 0, 0);
		push_pair(255, 0, 0);
		push_pair(0, 255, 0);
		push_pair(0, 255, 1);
		push_pair(200, 199, 1);
		push_pair(8'h55, 8'haa, 0);
		push_pair(8'haa, 8'h55, 0);
		push_pair(8'hf0, 8'h0f, 0);
		push_pair(8'h0f, 8'hf0, 1);
		push_pair(7, 7, 0);
		push_pair(9, 7, 1);
		wait_drained();

		// random images, mostly short
		queued = 0;
		while (queued < 1400) begin
			pick = $urandom_range(99);
			if (pick < 70)
				n = $urandom_range(1, 16);
			else if (pick < 95)
				n = $urandom_range(17, 64);
			else
				n = $urandom_range(65, 300);
			queue_image(n, $urandom_range(5));
			queued = queued + n;
		end
		wait_drained();

		// output held off while short images keep arriving, so the input stalls
		long_holds = long_holds + 1;
		for (i = 0; i < 12; i++)
			queue_image($urandom_range(1, 6), $urandom_range(3));
		wait_drained();

		// accumulators must be clear again after the stalled images
		queue_image(5, 0);
		wait_drained();
		repeat (40) @(posedge clk);

		$display("run: %0d pixel pairs, %0d images checked, %0d saturated",
			pairs_taken, images_done, ovf_images);
		$display("run: directed extremes, random images, a long output hold, idle drains");
		if (err_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
